// ===== rtl/core/rbe_pkg.sv =====
`timescale 1ns / 1ps

package rbe_pkg;

    localparam int STATE_W    = 23;
    localparam int LOWER_BITS = 15;
    localparam int FREQ_W     = 13;
    localparam int START_W    = 12;
    localparam int SYM_W      = 8;
    localparam int BYTE_W     = 8;
    localparam int KIND_W     = 2;
    localparam int IN_DATA_W  = 40;

    localparam int DEF_PROB_BITS     = 12;
    localparam int DEF_ALPHABET_SIZE = 256;

    localparam logic [STATE_W-1:0] LOWER_BOUND = STATE_W'(1) << LOWER_BITS;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD   = 2'd0,
        KIND_START  = 2'd1,
        KIND_ENCODE = 2'd2,
        KIND_FINISH = 2'd3
    } kind_t;

    typedef struct packed {
        logic error;
        logic is_state_byte;
    } out_user_t;

endpackage

// ===== rtl/core/rbe_ram.sv =====
`timescale 1ns / 1ps

module rbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/rbe_cmpsub.sv =====
`timescale 1ns / 1ps

// shared subtractor: renorm threshold test and divider steps
module rbe_cmpsub #(
    parameter int WIDTH = 28
) (
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    output logic [WIDTH-1:0] diff,
    output logic             ge
);

    logic [WIDTH:0] full;

    assign full = {1'b0, a} - {1'b0, b};
    assign diff = full[WIDTH-1:0];
    assign ge   = ~full[WIDTH];

endmodule

// ===== rtl/core/rans_byte_encoder.sv =====
`timescale 1ns / 1ps

// Byte-wise rANS encoder core with a 23-bit coder state and lower bound 2^15. Beats on the
// input carry a kind in tuser: load writes one symbol table entry, start resets the state,
// encode codes one symbol (supply symbols in reverse order), finish emits the state as four
// bytes, least significant first. Load and start give no output. Encode reads its table entry,
// runs one compare per renormalization test (one to three), emits each renormalization byte,
// then runs STATE_W - PROB_BITS divider steps (11 at the default scale) and one update step.
// The radix-2 divider shares one subtractor with the renormalization compare. A zero-frequency
// or out-of-range symbol gives one error beat. tready is low while an item is in work and
// while an emitted byte waits for the output register. The symbol table is not cleared at
// reset: encoding a symbol whose entry was never loaded gives undefined results.
module rans_byte_encoder #(
    parameter int PROB_BITS     = rbe_pkg::DEF_PROB_BITS,
    parameter int ALPHABET_SIZE = rbe_pkg::DEF_ALPHABET_SIZE
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // symbol [7:0], frequency [20:8], cumulative_start [32:21], zero fill
    input  logic [rbe_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // kind [1:0]
    input  logic [rbe_pkg::KIND_W-1:0]      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // out_byte [7:0]
    output logic [rbe_pkg::BYTE_W-1:0]      m_axis_tdata,
    // is_state_byte [0], error [1]
    output logic [1:0]                      m_axis_tuser,
    output logic                            m_axis_tlast
);

    import rbe_pkg::*;

    localparam int QUO_W   = STATE_W - PROB_BITS;
    localparam int LIM_W   = FREQ_W + QUO_W;
    localparam int CMP_W   = (LIM_W > STATE_W) ? LIM_W : STATE_W;
    localparam int REM_W   = FREQ_W + 1;
    localparam int CNT_W   = $clog2(QUO_W + 1);
    localparam int ADDR_W  = $clog2(ALPHABET_SIZE);
    localparam int ENTRY_W = FREQ_W + START_W;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_READ = 7'b0000010,
        ST_CMP  = 7'b0000100,
        ST_EMIT = 7'b0001000,
        ST_DIV  = 7'b0010000,
        ST_UPD  = 7'b0100000,
        ST_OUT  = 7'b1000000
    } fsm_t;

    fsm_t                fsm_reg, fsm_next;
    logic [STATE_W-1:0]  coder_reg, coder_next;
    logic [STATE_W-1:0]  st_reg, st_next;
    logic [FREQ_W-1:0]   freq_reg, freq_next;
    logic [START_W-1:0]  start_reg, start_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [QUO_W-1:0]    quo_reg, quo_next;
    logic [CNT_W-1:0]    div_cnt_reg, div_cnt_next;
    logic [1:0]          n_reg, n_next;
    logic [BYTE_W-1:0]   pend_reg, pend_next;
    logic                pend_vld_reg, pend_vld_next;
    logic                renorm_reg, renorm_next;
    logic                in_range_reg, in_range_next;
    logic                err_reg, err_next;

    logic                m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0]   m_data_reg, m_data_next;
    out_user_t           m_user_reg, m_user_next;
    logic                m_last_reg, m_last_next;

    kind_t               in_kind;
    logic [SYM_W-1:0]    in_sym;
    logic [FREQ_W-1:0]   in_freq;
    logic [START_W-1:0]  in_start;
    logic                in_accept;
    logic                sym_in_range;
    logic                out_free;

    logic                ram_we;
    logic                ram_re;
    logic [ENTRY_W-1:0]  ram_rdata;

    logic [CMP_W-1:0]    unit_a, unit_b, unit_diff;
    logic                unit_ge;
    logic [REM_W-1:0]    div_shift;
    logic [31:0]         coder_wide;

    assign s_axis_tready = (fsm_reg == ST_IDLE);

    assign in_kind      = kind_t'(s_axis_tuser);
    assign in_sym       = s_axis_tdata[SYM_W-1:0];
    assign in_freq      = s_axis_tdata[SYM_W +: FREQ_W];
    assign in_start     = s_axis_tdata[SYM_W+FREQ_W +: START_W];
    assign in_accept    = s_axis_tvalid && s_axis_tready;
    assign sym_in_range = (9'(in_sym) < 9'(ALPHABET_SIZE));
    assign out_free     = !m_valid_reg || m_axis_tready;

    assign ram_we = in_accept && (in_kind == KIND_LOAD) && sym_in_range;
    assign ram_re = in_accept && (in_kind == KIND_ENCODE);

    rbe_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ALPHABET_SIZE)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (in_sym[ADDR_W-1:0]),
        .wdata ({in_start, in_freq}),
        .re    (ram_re),
        .raddr (in_sym[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // divider step: bring down the next dividend bit
    assign div_shift = {rem_reg[REM_W-2:0], quo_reg[QUO_W-1]};

    always_comb
    begin
        if (fsm_reg == ST_DIV)
        begin
            unit_a = CMP_W'(div_shift);
            unit_b = CMP_W'(freq_reg);
        end
        else
        begin
            unit_a = CMP_W'(st_reg);
            unit_b = CMP_W'(freq_reg) << QUO_W;
        end
    end

    rbe_cmpsub #(
        .WIDTH (CMP_W)
    ) u_unit (
        .a    (unit_a),
        .b    (unit_b),
        .diff (unit_diff),
        .ge   (unit_ge)
    );

    assign coder_wide = 32'(coder_reg);

    always_comb
    begin
        fsm_next      = fsm_reg;
        coder_next    = coder_reg;
        st_next       = st_reg;
        freq_next     = freq_reg;
        start_next    = start_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        div_cnt_next  = div_cnt_reg;
        n_next        = n_reg;
        pend_next     = pend_reg;
        pend_vld_next = pend_vld_reg;
        renorm_next   = renorm_reg;
        in_range_next = in_range_reg;
        err_next      = err_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;
        m_last_next   = m_last_reg;

        case (fsm_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    n_next = 2'd0;
                    case (in_kind)
                        KIND_START:
                        begin
                            coder_next = LOWER_BOUND;
                        end
                        KIND_ENCODE:
                        begin
                            in_range_next = sym_in_range;
                            fsm_next      = ST_READ;
                        end
                        KIND_FINISH:
                        begin
                            err_next = 1'b0;
                            fsm_next = ST_OUT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                freq_next     = ram_rdata[FREQ_W-1:0];
                start_next    = ram_rdata[FREQ_W +: START_W];
                st_next       = coder_reg;
                pend_vld_next = 1'b0;
                if (!in_range_reg || (ram_rdata[FREQ_W-1:0] == '0))
                begin
                    err_next = 1'b1;
                    fsm_next = ST_OUT;
                end
                else
                begin
                    fsm_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                renorm_next = unit_ge && (n_reg != 2'd2);
                if (pend_vld_reg)
                begin
                    // last flag of the held byte waits on this test
                    fsm_next = ST_EMIT;
                end
                else if (unit_ge && (n_reg != 2'd2))
                begin
                    pend_next     = st_reg[BYTE_W-1:0];
                    pend_vld_next = 1'b1;
                    st_next       = st_reg >> BYTE_W;
                    n_next        = n_reg + 2'd1;
                end
                else
                begin
                    rem_next     = REM_W'(st_reg >> QUO_W);
                    quo_next     = st_reg[QUO_W-1:0];
                    div_cnt_next = CNT_W'(QUO_W);
                    fsm_next     = ST_DIV;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_data_next   = pend_reg;
                    m_user_next   = '{error: 1'b0, is_state_byte: 1'b0};
                    m_last_next   = !renorm_reg;
                    pend_vld_next = 1'b0;
                    if (renorm_reg)
                    begin
                        pend_next     = st_reg[BYTE_W-1:0];
                        pend_vld_next = 1'b1;
                        st_next       = st_reg >> BYTE_W;
                        n_next        = n_reg + 2'd1;
                        fsm_next      = ST_CMP;
                    end
                    else
                    begin
                        rem_next     = REM_W'(st_reg >> QUO_W);
                        quo_next     = st_reg[QUO_W-1:0];
                        div_cnt_next = CNT_W'(QUO_W);
                        fsm_next     = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                rem_next     = unit_ge ? unit_diff[REM_W-1:0] : div_shift;
                quo_next     = {quo_reg[QUO_W-2:0], unit_ge};
                div_cnt_next = div_cnt_reg - CNT_W'(1);
                if (div_cnt_reg == CNT_W'(1))
                begin
                    fsm_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                coder_next = {quo_reg, {PROB_BITS{1'b0}}} + STATE_W'(start_reg)
                           + STATE_W'(rem_reg);
                fsm_next   = ST_IDLE;
            end
            ST_OUT:
            begin
                // error beat, or one of the four state bytes
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    if (err_reg)
                    begin
                        m_data_next = '0;
                        m_user_next = '{error: 1'b1, is_state_byte: 1'b0};
                        m_last_next = 1'b1;
                        fsm_next    = ST_IDLE;
                    end
                    else
                    begin
                        m_data_next = coder_wide[{n_reg, 3'b000} +: BYTE_W];
                        m_user_next = '{error: 1'b0, is_state_byte: 1'b1};
                        m_last_next = (n_reg == 2'd3);
                        n_next      = n_reg + 2'd1;
                        if (n_reg == 2'd3)
                        begin
                            fsm_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                fsm_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg      <= ST_IDLE;
            coder_reg    <= LOWER_BOUND;
            m_valid_reg  <= 1'b0;
            pend_vld_reg <= 1'b0;
            n_reg        <= 2'd0;
            div_cnt_reg  <= '0;
        end
        else
        begin
            fsm_reg      <= fsm_next;
            coder_reg    <= coder_next;
            m_valid_reg  <= m_valid_next;
            pend_vld_reg <= pend_vld_next;
            n_reg        <= n_next;
            div_cnt_reg  <= div_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg       <= st_next;
        freq_reg     <= freq_next;
        start_reg    <= start_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        pend_reg     <= pend_next;
        renorm_reg   <= renorm_next;
        in_range_reg <= in_range_next;
        err_reg      <= err_next;
        m_data_reg   <= m_data_next;
        m_user_reg   <= m_user_next;
        m_last_reg   <= m_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

// ===== bench/tb_rans_byte_encoder.sv =====
`timescale 1ns / 1ps

module tb_rans_byte_encoder;
    import rbe_pkg::*;

    localparam int          RANDOM_ITEMS = 190;
    localparam int          N_DIRECTED   = 22;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          BIG_HOLD     = 400;
    localparam int          DRAIN_CYCLES = 40;
    // renormalize while state >= ((lower bound >> scale) << 8) * freq
    localparam logic [31:0] RENORM_UNIT  = 32'((1 << (LOWER_BITS - DEF_PROB_BITS)) << BYTE_W);

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              state_byte;
        logic              err;
        logic              last;
    } beat_t;

    typedef enum {
        WANT_MODEL,
        WANT_NONE,
        WANT_ERROR,
        WANT_RESET_WORD
    } want_t;

    typedef struct {
        kind_t              k;
        logic [SYM_W-1:0]   sym;
        logic [FREQ_W-1:0]  freq;
        logic [START_W-1:0] cstart;
        want_t              want;
    } dir_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;
    logic [KIND_W-1:0]    s_axis_tuser = KIND_LOAD;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [BYTE_W-1:0]    m_axis_tdata;
    logic [1:0]           m_axis_tuser;
    logic                 m_axis_tlast;

    // shadow of the coder
    logic [FREQ_W-1:0]    tbl_freq [256];
    logic [START_W-1:0]   tbl_start [256];
    bit                   was_loaded [256];
    logic [SYM_W-1:0]     loaded_syms [$];
    logic [STATE_W-1:0]   coder_state = LOWER_BOUND;

    beat_t                pending_beats [$];
    int                   mismatches = 0;
    int                   beats_seen = 0;
    int                   items_sent = 0;
    int                   quiet_sends = 0;
    int                   cycle_count = 0;

    dir_row_t             dir_rows [N_DIRECTED];

    rans_byte_encoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [FREQ_W-1:0] pick_freq();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r == 1)
            return FREQ_W'($urandom_range(4097, 8191));
        if (r == 2)
            return FREQ_W'(4096);
        if (r < 9)
            return FREQ_W'($urandom_range(1, 32));
        return FREQ_W'($urandom_range(1, 4096));
    endfunction

    // advance the shadow coder by one item and list the bytes it puts out
    function automatic void encode_beats(kind_t k, logic [SYM_W-1:0] sym,
                                         logic [FREQ_W-1:0] freq, logic [START_W-1:0] cstart,
                                         ref beat_t beats [$]);
        logic [FREQ_W-1:0]  f;
        logic [31:0]        bound;
        logic [STATE_W-1:0] st;
        logic [STATE_W-1:0] quo;
        logic [STATE_W-1:0] rem;
        logic [47:0]        nxt;
        logic [31:0]        word;
        int                 n;
        beats = {};
        case (k)
            KIND_LOAD:
            begin
                tbl_freq[sym]  = freq;
                tbl_start[sym] = cstart;
                if (!was_loaded[sym])
                begin
                    was_loaded[sym] = 1'b1;
                    loaded_syms.push_back(sym);
                end
            end
            KIND_START:
                coder_state = LOWER_BOUND;
            KIND_ENCODE:
            begin
                f = tbl_freq[sym];
                if (f == '0)
                    beats.push_back('{data: '0, state_byte: 1'b0, err: 1'b1, last: 1'b1});
                else
                begin
                    bound = RENORM_UNIT * f;
                    st    = coder_state;
                    n     = 0;
                    while (n < 2 && 32'(st) >= bound)
                    begin
                        beats.push_back('{data: st[BYTE_W-1:0], state_byte: 1'b0,
                                          err: 1'b0, last: 1'b0});
                        st = st >> BYTE_W;
                        n++;
                    end
                    if (n > 0)
                        beats[n-1].last = 1'b1;
                    quo = st / f;
                    rem = st % f;
                    nxt = (48'(quo) << DEF_PROB_BITS) + 48'(tbl_start[sym]) + 48'(rem);
                    coder_state = nxt[STATE_W-1:0];
                end
            end
            default:
            begin
                word = 32'(coder_state);
                for (int i = 0; i < 4; i++)
                    beats.push_back('{data: word[8*i +: 8], state_byte: 1'b1, err: 1'b0,
                                      last: (i == 3)});
            end
        endcase
    endfunction

    task automatic send_item(kind_t k, logic [SYM_W-1:0] sym, logic [FREQ_W-1:0] freq,
                             logic [START_W-1:0] cstart, want_t want);
        int    gap;
        beat_t beats [$];
        if (quiet_sends > 0)
        begin
            gap = 0;
            quiet_sends--;
        end
        else
        begin
            gap = pick_gap();
            if ($urandom_range(0, 24) == 0)
                quiet_sends = $urandom_range(8, 30);
        end
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        encode_beats(k, sym, freq, cstart, beats);
        case (want)
            WANT_MODEL:
                foreach (beats[i])
                    pending_beats.push_back(beats[i]);
            WANT_ERROR:
                pending_beats.push_back('{data: 8'h00, state_byte: 1'b0, err: 1'b1, last: 1'b1});
            WANT_RESET_WORD:
            begin
                // 32768 least significant byte first
                pending_beats.push_back('{data: 8'h00, state_byte: 1'b1, err: 1'b0, last: 1'b0});
                pending_beats.push_back('{data: 8'h80, state_byte: 1'b1, err: 1'b0, last: 1'b0});
                pending_beats.push_back('{data: 8'h00, state_byte: 1'b1, err: 1'b0, last: 1'b0});
                pending_beats.push_back('{data: 8'h00, state_byte: 1'b1, err: 1'b0, last: 1'b1});
            end
            default:
                ;
        endcase
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, cstart, freq, sym};
        s_axis_tuser  <= k;
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_beats.size() != 0);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        if (mismatches <= 40)
            $display("%0t ns mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    endtask

    always @(posedge clk)
    begin : watch
        beat_t head;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            beats_seen++;
            if (pending_beats.size() == 0)
                report_mismatch("beat with nothing pending, data", m_axis_tdata, 0);
            else
            begin
                head = pending_beats.pop_front();
                if (m_axis_tdata !== head.data)
                    report_mismatch("out_byte", m_axis_tdata, head.data);
                if (m_axis_tuser[0] !== head.state_byte)
                    report_mismatch("is_state_byte", m_axis_tuser[0], head.state_byte);
                if (m_axis_tuser[1] !== head.err)
                    report_mismatch("error", m_axis_tuser[1], head.err);
                if (m_axis_tlast !== head.last)
                    report_mismatch("last", m_axis_tlast, head.last);
            end
        end
    end

    // output side: random stalls, quiet stretches and one long hold-off
    initial
    begin : sink
        int hold_left;
        int calm_left;
        bit big_hold_done;
        hold_left     = 0;
        calm_left     = 0;
        big_hold_done = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!big_hold_done && beats_seen >= 30)
            begin
                big_hold_done = 1'b1;
                hold_left     = BIG_HOLD;
                m_axis_tready <= 1'b0;
            end
            else if (calm_left > 0)
            begin
                calm_left--;
                m_axis_tready <= 1'b1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                hold_left = pick_gap();
                if ($urandom_range(0, 15) == 0)
                    calm_left = $urandom_range(20, 80);
            end
        end
    end

    initial
    begin : source
        logic [SYM_W-1:0] sym;
        logic [SYM_W-1:0] block_syms [$];
        bit               paused_mid;
        paused_mid = 1'b0;

        dir_rows = '{
            '{KIND_FINISH, 8'd0,   13'd0,    12'd0,    WANT_RESET_WORD},
            '{KIND_LOAD,   8'd5,   13'd0,    12'd100,  WANT_NONE},
            '{KIND_ENCODE, 8'd5,   13'd0,    12'd0,    WANT_ERROR},
            '{KIND_FINISH, 8'd0,   13'd0,    12'd0,    WANT_RESET_WORD},
            '{KIND_LOAD,   8'd255, 13'd4096, 12'd0,    WANT_NONE},
            // full-scale frequency leaves 32768 as it is
            '{KIND_ENCODE, 8'd255, 13'd0,    12'd0,    WANT_NONE},
            '{KIND_FINISH, 8'd0,   13'd0,    12'd0,    WANT_RESET_WORD},
            '{KIND_LOAD,   8'd0,   13'd1,    12'd4095, WANT_NONE},
            '{KIND_ENCODE, 8'd0,   13'h1fff, 12'hfff,  WANT_MODEL},
            '{KIND_ENCODE, 8'd0,   13'd0,    12'd0,    WANT_MODEL},
            '{KIND_FINISH, 8'hff,  13'h1fff, 12'hfff,  WANT_MODEL},
            '{KIND_FINISH, 8'd0,   13'd0,    12'd0,    WANT_MODEL},
            // frequency above the scale
            '{KIND_LOAD,   8'd170, 13'h1fff, 12'hfff,  WANT_NONE},
            '{KIND_ENCODE, 8'd170, 13'd0,    12'd0,    WANT_MODEL},
            '{KIND_START,  8'd0,   13'd0,    12'd0,    WANT_NONE},
            '{KIND_LOAD,   8'd1,   13'd16,   12'd4095, WANT_NONE},
            '{KIND_ENCODE, 8'd1,   13'd0,    12'd0,    WANT_MODEL},
            // start plus frequency past the scale, next state wraps at 23 bits
            '{KIND_LOAD,   8'd2,   13'd18,   12'd4095, WANT_NONE},
            '{KIND_ENCODE, 8'd2,   13'd0,    12'd0,    WANT_MODEL},
            '{KIND_FINISH, 8'd0,   13'd0,    12'd0,    WANT_MODEL},
            '{KIND_ENCODE, 8'd2,   13'd0,    12'd0,    WANT_MODEL},
            '{KIND_FINISH, 8'd0,   13'd0,    12'd0,    WANT_MODEL}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].k, dir_rows[i].sym, dir_rows[i].freq, dir_rows[i].cstart,
                      dir_rows[i].want);
        wait_drained();

        while (items_sent < N_DIRECTED + RANDOM_ITEMS)
        begin
            if (!paused_mid && items_sent >= N_DIRECTED + RANDOM_ITEMS / 2)
            begin
                paused_mid = 1'b1;
                wait_drained();
            end
            if ($urandom_range(0, 9) < 7)
            begin
                // load some entries, start, encode a run of symbols, finish
                block_syms = {};
                repeat ($urandom_range(1, 5))
                begin
                    sym = SYM_W'($urandom);
                    block_syms.push_back(sym);
                    send_item(KIND_LOAD, sym, pick_freq(), START_W'($urandom), WANT_MODEL);
                end
                send_item(KIND_START, SYM_W'($urandom), FREQ_W'($urandom), START_W'($urandom),
                          WANT_MODEL);
                repeat ($urandom_range(3, 12))
                begin
                    if ($urandom_range(0, 4) == 0)
                        sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
                    else
                        sym = block_syms[$urandom_range(0, block_syms.size() - 1)];
                    send_item(KIND_ENCODE, sym, FREQ_W'($urandom), START_W'($urandom),
                              WANT_MODEL);
                end
                send_item(KIND_FINISH, SYM_W'($urandom), FREQ_W'($urandom), START_W'($urandom),
                          WANT_MODEL);
            end
            else
            begin
                case (kind_t'($urandom_range(0, 3)))
                    KIND_LOAD:
                        send_item(KIND_LOAD, SYM_W'($urandom), FREQ_W'($urandom),
                                  START_W'($urandom), WANT_MODEL);
                    KIND_START:
                        send_item(KIND_START, SYM_W'($urandom), FREQ_W'($urandom),
                                  START_W'($urandom), WANT_MODEL);
                    KIND_ENCODE:
                        send_item(KIND_ENCODE,
                                  loaded_syms[$urandom_range(0, loaded_syms.size() - 1)],
                                  FREQ_W'($urandom), START_W'($urandom), WANT_MODEL);
                    default:
                        send_item(KIND_FINISH, SYM_W'($urandom), FREQ_W'($urandom),
                                  START_W'($urandom), WANT_MODEL);
                endcase
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
